FILE: rtl/core/bba_pkg.sv
`default_nettype none

package bba_pkg;

  localparam int unsigned NumBlocks = 64;
  localparam int unsigned MaxGrant  = 64;
  localparam int unsigned BlkW      = $clog2(NumBlocks);
  localparam int unsigned CntW      = 7;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoSpace  = 2'd1,
    StNotAlloc = 2'd2,
    StZero     = 2'd3
  } status_e;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic [BlkW-1:0] addr;
    logic            wr_bit;
  } mem_req_t;

  typedef struct packed {
    logic            load;
    logic [BlkW-1:0] blk;
    status_e         status;
    logic            last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/bba_map_mem.sv
`default_nettype none

module bba_map_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bba_pkg::mem_req_t req_i,
  output logic              rd_data_o
);
  import bba_pkg::*;

  logic                 mem_q [NumBlocks];
  logic [NumBlocks-1:0] vld_q;
  logic                 data_q;
  logic                 data_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wr_bit;
    end
    if (req_i.rd_en) begin
      data_q <= mem_q[req_i.addr];
    end
  end

  // never-written entries read as free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      data_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        data_vld_q <= vld_q[req_i.addr];
      end
    end
  end

  assign rd_data_o = data_vld_q & data_q;

endmodule

`default_nettype wire

FILE: rtl/core/bba_ctrl.sv
`default_nettype none

module bba_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_op_i,
  input  logic [bba_pkg::CntW-1:0]   in_count_i,
  input  logic [bba_pkg::BlkW-1:0]   in_index_i,
  input  logic                       slot_free_i,
  output bba_pkg::res_t              res_o,
  output bba_pkg::mem_req_t          mem_req_o,
  input  logic                       rd_data_i
);
  import bba_pkg::*;

  typedef enum logic [6:0] {
    SIdle   = 7'b0000001,
    SScan   = 7'b0000010,
    SEmit   = 7'b0000100,
    SFbRd   = 7'b0001000,
    SFbEv   = 7'b0010000,
    SFreeEv = 7'b0100000,
    SErr    = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [BlkW-1:0] addr_q, addr_d;
  logic [BlkW-1:0] cur_q, cur_d;
  logic [CntW-1:0] run_q, run_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] free_q, free_d;
  status_e         err_q, err_d;

  logic [CntW-1:0] run_nx;
  logic [CntW-1:0] start;

  assign run_nx = run_q + CntW'(1);
  assign start  = {1'b0, cur_q} + CntW'(1) - n_q;

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    cur_d      = cur_q;
    run_d      = run_q;
    n_d        = n_q;
    rem_d      = rem_q;
    free_d     = free_q;
    err_d      = err_q;
    in_ready_o = 1'b0;
    mem_req_o  = '0;
    res_o      = '0;
    res_o.status = StOk;

    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OpFree) begin
            mem_req_o.rd_en = 1'b1;
            mem_req_o.addr  = in_index_i;
            addr_d          = in_index_i;
            state_d         = SFreeEv;
          end else if (in_count_i == '0) begin
            err_d   = StZero;
            state_d = SErr;
          end else if (in_count_i > CntW'(MaxGrant) || in_count_i > free_q) begin
            err_d   = StNoSpace;
            state_d = SErr;
          end else begin
            mem_req_o.rd_en = 1'b1;
            mem_req_o.addr  = '0;
            cur_d           = '0;
            run_d           = '0;
            n_d             = in_count_i;
            free_d          = free_q - in_count_i;
            state_d         = SScan;
          end
        end
      end

      // one bitmap entry evaluated per cycle, next read issued alongside
      SScan: begin
        if (!rd_data_i && run_nx == n_q) begin
          addr_d  = start[BlkW-1:0];
          rem_d   = n_q;
          state_d = SEmit;
        end else begin
          run_d = rd_data_i ? '0 : run_nx;
          if (cur_q == BlkW'(NumBlocks - 1)) begin
            addr_d  = '0;
            rem_d   = n_q;
            state_d = SFbRd;
          end else begin
            mem_req_o.rd_en = 1'b1;
            mem_req_o.addr  = cur_q + BlkW'(1);
            cur_d           = cur_q + BlkW'(1);
          end
        end
      end

      SEmit: begin
        if (slot_free_i) begin
          mem_req_o.wr_en  = 1'b1;
          mem_req_o.addr   = addr_q;
          mem_req_o.wr_bit = 1'b1;
          res_o.load       = 1'b1;
          res_o.blk        = addr_q;
          res_o.last       = (rem_q == CntW'(1));
          addr_d           = addr_q + BlkW'(1);
          rem_d            = rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_d = SIdle;
          end
        end
      end

      SFbRd: begin
        mem_req_o.rd_en = 1'b1;
        mem_req_o.addr  = addr_q;
        state_d         = SFbEv;
      end

      SFbEv: begin
        if (rd_data_i) begin
          addr_d  = addr_q + BlkW'(1);
          state_d = SFbRd;
        end else if (slot_free_i) begin
          mem_req_o.wr_en  = 1'b1;
          mem_req_o.addr   = addr_q;
          mem_req_o.wr_bit = 1'b1;
          res_o.load       = 1'b1;
          res_o.blk        = addr_q;
          res_o.last       = (rem_q == CntW'(1));
          addr_d           = addr_q + BlkW'(1);
          rem_d            = rem_q - CntW'(1);
          state_d          = (rem_q == CntW'(1)) ? SIdle : SFbRd;
        end
      end

      SFreeEv: begin
        if (slot_free_i) begin
          res_o.load   = 1'b1;
          res_o.blk    = addr_q;
          res_o.last   = 1'b1;
          res_o.status = rd_data_i ? StOk : StNotAlloc;
          if (rd_data_i) begin
            mem_req_o.wr_en  = 1'b1;
            mem_req_o.addr   = addr_q;
            mem_req_o.wr_bit = 1'b0;
            free_d           = free_q + CntW'(1);
          end
          state_d = SIdle;
        end
      end

      SErr: begin
        if (slot_free_i) begin
          res_o.load   = 1'b1;
          res_o.blk    = '0;
          res_o.last   = 1'b1;
          res_o.status = err_q;
          state_d      = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      free_q  <= CntW'(NumBlocks);
      addr_q  <= '0;
      cur_q   <= '0;
      run_q   <= '0;
      n_q     <= '0;
      rem_q   <= '0;
      err_q   <= StOk;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      addr_q  <= addr_d;
      cur_q   <= cur_d;
      run_q   <= run_d;
      n_q     <= n_d;
      rem_q   <= rem_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bitmap_block_allocator_unit.sv
`default_nettype none
// Free request or allocate error: one result word, registered once the output is free.
// Allocate: bitmap scan at one entry per cycle from block 0, then one granted word per
// cycle unless the output stalls; without a contiguous run, a fallback pass reads and
// then evaluates each entry in turn from block 0. One request at a time. Reset clears
// state at once: unwritten bitmap entries read as free, no clearing pass.
module bitmap_block_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // block_count[6:0], block_index[12:7], zero fill
  input  logic        s_axis_tuser_i,   // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // granted_block[5:0], status[7:6]
  output logic        m_axis_tlast_o    // last_of_run
);
  import bba_pkg::*;

  res_t            res;
  mem_req_t        mem_req;
  logic            rd_data;
  logic            slot_free;
  logic            out_valid_q;
  logic [BlkW-1:0] out_blk_q;
  status_e         out_status_q;
  logic            out_last_q;

  assign slot_free = !out_valid_q || m_axis_tready_i;

  bba_map_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .in_count_i  (s_axis_tdata_i[CntW-1:0]),
    .in_index_i  (s_axis_tdata_i[CntW+BlkW-1:CntW]),
    .slot_free_i (slot_free),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res.load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && res.load) begin
      out_blk_q    <= res.blk;
      out_status_q <= res.status;
      out_last_q   <= res.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_status_q, out_blk_q};
  assign m_axis_tlast_o  = out_last_q;

  a_ready_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !res.load)
    else $error("result produced while idle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load |-> slot_free)
    else $error("result overwrites pending word");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_status_q != StOk) |-> m_axis_tlast_o)
    else $error("error word not flagged last");

endmodule

`default_nettype wire

FILE: tb/bitmap_grant_checker.sv
module bitmap_grant_checker
  import bba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,   // block_count[6:0], block_index[12:7], zero fill
  input  logic        s_axis_tuser_i,   // operation
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // granted_block[5:0], status[7:6]
  input  logic        m_axis_tlast_i,   // last_of_run
  output int          mismatch_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [BlkW-1:0] blk;
    status_e         status;
    logic            last;
  } grant_t;

  grant_t               grant_queue[$];
  logic [NumBlocks-1:0] used_shadow;
  int unsigned          free_shadow;
  int                   mismatches;

  function automatic void queue_grant(int unsigned blk, status_e st, logic last);
    grant_t g;
    g.blk    = BlkW'(blk);
    g.status = st;
    g.last   = last;
    grant_queue.push_back(g);
  endfunction

  // first fit over the shadow bitmap, falling back to the lowest free blocks
  function automatic void predict_request(op_e op, logic [CntW-1:0] cnt,
                                          logic [BlkW-1:0] idx);
    int unsigned run;
    int unsigned start;
    int unsigned taken;
    bit          found;
    run   = 0;
    start = 0;
    taken = 0;
    found = 1'b0;
    if (op == OpFree) begin
      if (used_shadow[idx]) begin
        used_shadow[idx] = 1'b0;
        free_shadow++;
        queue_grant(idx, StOk, 1'b1);
      end else begin
        queue_grant(idx, StNotAlloc, 1'b1);
      end
    end else if (cnt == 0) begin
      queue_grant(0, StZero, 1'b1);
    end else if (cnt > MaxGrant || cnt > free_shadow) begin
      queue_grant(0, StNoSpace, 1'b1);
    end else begin
      for (int i = 0; i < NumBlocks && !found; i++) begin
        if (!used_shadow[i]) begin
          run++;
          if (run == cnt) begin
            found = 1'b1;
            start = i + 1 - cnt;
          end
        end else begin
          run = 0;
        end
      end
      if (found) begin
        for (int j = 0; j < cnt; j++) begin
          used_shadow[start + j] = 1'b1;
          queue_grant(start + j, StOk, j + 1 == cnt);
        end
      end else begin
        for (int i = 0; i < NumBlocks && taken < cnt; i++) begin
          if (!used_shadow[i]) begin
            used_shadow[i] = 1'b1;
            queue_grant(i, StOk, taken + 1 == cnt);
            taken++;
          end
        end
      end
      free_shadow -= cnt;
    end
  endfunction

  function automatic void check_word(logic [7:0] data, logic last);
    grant_t          want;
    logic [BlkW-1:0] got_blk;
    logic [1:0]      got_st;
    got_blk = data[BlkW-1:0];
    got_st  = data[7:6];
    if (grant_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected word blk=%0d status=%0d last=%0b",
                 $realtime, got_blk, got_st, last);
    end else begin
      want = grant_queue.pop_front();
      if (got_blk !== want.blk || got_st !== want.status || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: word mismatch exp blk=%0d status=%0d last=%0b got blk=%0d status=%0d last=%0b",
                   $realtime, want.blk, want.status, want.last, got_blk, got_st, last);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grant_queue.delete();
      used_shadow      = '0;
      free_shadow      = NumBlocks;
      mismatches       = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_word(m_axis_tdata_i, m_axis_tlast_i);
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_request(op_e'(s_axis_tuser_i), s_axis_tdata_i[6:0], s_axis_tdata_i[12:7]);
      mismatch_count_o <= mismatches;
      pending_o        <= grant_queue.size();
    end
  end

endmodule

FILE: tb/bitmap_block_allocator_unit_test.sv
module bitmap_block_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int StallLimit  = 20000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 200;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [15:0] s_data;
  logic        s_user;
  logic        m_valid;
  logic        m_ready;
  logic [7:0]  m_data;
  logic        m_last;

  int mismatch_count;
  int pending;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  bit hold_done      = 1'b0;

  always #5 clk = ~clk;

  bitmap_block_allocator_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  bitmap_grant_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_valid),
    .s_axis_tready_i  (s_ready),
    .s_axis_tdata_i   (s_data),
    .s_axis_tuser_i   (s_user),
    .m_axis_tvalid_i  (m_valid),
    .m_axis_tready_i  (m_ready),
    .m_axis_tdata_i   (m_data),
    .m_axis_tlast_i   (m_last),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    m_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end
      m_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic push_request(op_e op, logic [6:0] cnt, logic [5:0] idx);
    if (send_idle_pct > 0) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        s_valid <= 1'b0;
        @(posedge clk);
      end
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {3'b000, idx, cnt};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  task automatic random_request();
    int unsigned pick;
    logic [6:0]  cnt;
    logic [5:0]  idx;
    pick = $urandom_range(0, 99);
    cnt  = 7'($urandom);
    idx  = 6'($urandom);
    if (pick < 35) cnt = 7'($urandom_range(1, 4));
    else if (pick < 42) cnt = 7'($urandom_range(5, 16));
    else if (pick < 46) cnt = 7'($urandom_range(17, 127));
    else if (pick < 49) cnt = '0;
    if (pick < 49) push_request(OpAlloc, cnt, idx);
    else push_request(OpFree, cnt, idx);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) random_request();
    wait_drained();
  endtask

  initial begin
    rst_n   = 1'b0;
    s_valid = 1'b0;
    s_data  = '0;
    s_user  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero count, stray free, oversized, whole map, full map
    push_request(OpAlloc, 7'd0, 6'($urandom));
    push_request(OpFree, 7'($urandom), 6'd5);
    push_request(OpAlloc, 7'd127, 6'($urandom));
    push_request(OpAlloc, 7'd65, 6'($urandom));
    push_request(OpAlloc, 7'd64, 6'($urandom));
    push_request(OpAlloc, 7'd1, 6'($urandom));
    // fragment the map, then hit contiguous, too-few and fallback paths
    push_request(OpFree, 7'($urandom), 6'd0);
    push_request(OpFree, 7'($urandom), 6'd63);
    push_request(OpFree, 7'($urandom), 6'd10);
    push_request(OpFree, 7'($urandom), 6'd11);
    push_request(OpFree, 7'($urandom), 6'd10);
    push_request(OpAlloc, 7'd2, 6'($urandom));
    push_request(OpAlloc, 7'd3, 6'($urandom));
    push_request(OpFree, 7'($urandom), 6'd20);
    push_request(OpAlloc, 7'd3, 6'($urandom));
    push_request(OpFree, 7'($urandom), 6'd31);
    wait_drained();

    run_phase(32, 0, 0);
    run_phase(30, 83, 0);
    run_phase(30, 0, 83);
    run_phase(30, 18, 18);

    // back-pressure: results held off while requests keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    repeat (8) random_request();
    wait_drained();

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
